### design/prc_pkg.sv
// Package for the packet rule classifier: payload structs, cause codes and
// protocol numbers. No dependencies.
`timescale 1ns / 1ps

package prc_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned IndexW = 6;
  localparam int unsigned HitW   = 7;

  // op codes
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // verdicts
  localparam logic VERDICT_ACCEPT = 1'b0;
  localparam logic VERDICT_DROP   = 1'b1;

  // cause codes
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_WHITELIST = 3'd1;
  localparam logic [2:0] CAUSE_UNKNOWN   = 3'd2;
  localparam logic [2:0] CAUSE_DROP      = 3'd3;
  localparam logic [2:0] CAUSE_WRITE     = 3'd4;

  localparam logic [HitW-1:0] NO_HIT = 7'd64;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ANY  = 8'd0;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_EGP  = 8'd8;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_IPV6 = 8'd41;
  localparam logic [7:0] PROTO_OSPF = 8'd89;

  // ICMP types
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;

  typedef struct packed {
    logic              op;
    logic [IndexW-1:0] rule_index;
    logic [7:0]        protocol;
    logic [31:0]       src_addr;
    logic [31:0]       dst_addr;
    logic [15:0]       src_port;
    logic [15:0]       dst_port;
    logic [7:0]        icmp_type;
    logic              whitelist;
  } in_item_t;

  typedef struct packed {
    logic            verdict;
    logic [2:0]      cause;
    logic [HitW-1:0] rule_hit;
  } out_item_t;

  // one slot of the cell chain
  typedef struct packed {
    logic      valid;
    in_item_t  item;
    logic      decided;
    out_item_t res;
  } stage_t;

endpackage

### design/prc_cell.sv
// One rule cell: holds a single rule and checks the transaction passing by.
// Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_cell import prc_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [CountW-1:0] rule_count,
  input  stage_t            st_in,
  output stage_t            st_out
);

  localparam logic [HitW-1:0] HIT_CODE = HitW'(CELL_IDX);

  logic        kind_r;
  logic [7:0]  proto_r;
  logic [31:0] sa_r;
  logic [31:0] da_r;
  logic [15:0] sp_r;
  logic [15:0] dp_r;
  stage_t      st_r;
  stage_t      st_nxt;

  logic is_write;
  logic active;
  logic cross_ok;
  logic straight_ok;
  logic port_ok;
  logic hit;
  logic unknown;

  assign is_write = st_in.valid && (st_in.item.op == OP_WRITE) &&
                    (32'(st_in.item.rule_index) == CELL_IDX);
  assign active   = 32'(rule_count) > CELL_IDX;

  // zero in a rule field is a wildcard
  assign cross_ok    = ((sa_r == '0) || (sa_r == st_in.item.dst_addr)) &&
                       ((da_r == '0) || (da_r == st_in.item.src_addr));
  assign straight_ok = ((sa_r == '0) || (sa_r == st_in.item.src_addr)) &&
                       ((da_r == '0) || (da_r == st_in.item.dst_addr));
  assign port_ok     = ((sp_r == '0) || (sp_r == st_in.item.src_port)) &&
                       ((dp_r == '0) || (dp_r == st_in.item.dst_port));

  always_comb begin
    hit     = 1'b0;
    unknown = 1'b0;
    if (proto_r == PROTO_ANY) begin
      hit = cross_ok;
    end else if (proto_r == st_in.item.protocol) begin
      case (proto_r) inside
        PROTO_ICMP: begin
          if (st_in.item.icmp_type == ICMP_ECHO_REPLY) begin
            hit = cross_ok;
          end else if (st_in.item.icmp_type == ICMP_ECHO_REQ) begin
            hit = straight_ok;
          end
        end
        PROTO_TCP, PROTO_UDP: hit = straight_ok && port_ok;
        PROTO_IGMP, PROTO_EGP, PROTO_IPV6, PROTO_OSPF: hit = cross_ok;
        default: unknown = 1'b1;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_in;
    if (st_in.valid && !st_in.decided && (st_in.item.op == OP_CLASSIFY) && active) begin
      if (kind_r && (da_r == st_in.item.dst_addr)) begin
        st_nxt.decided = 1'b1;
        st_nxt.res     = '{verdict: VERDICT_ACCEPT, cause: CAUSE_WHITELIST,
                           rule_hit: HIT_CODE};
      end else if (unknown) begin
        st_nxt.decided = 1'b1;
        st_nxt.res     = '{verdict: VERDICT_ACCEPT, cause: CAUSE_UNKNOWN,
                           rule_hit: HIT_CODE};
      end else if (hit) begin
        st_nxt.decided = 1'b1;
        st_nxt.res     = '{verdict: VERDICT_DROP, cause: CAUSE_DROP,
                           rule_hit: HIT_CODE};
      end
    end
  end

  // rule storage, no reset: slots are defined once written
  always_ff @(posedge clk) begin
    if (adv && is_write) begin
      kind_r  <= st_in.item.whitelist;
      proto_r <= st_in.item.protocol;
      sa_r    <= st_in.item.src_addr;
      da_r    <= st_in.item.dst_addr;
      sp_r    <= st_in.item.src_port;
      dp_r    <= st_in.item.dst_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

### design/packet_rule_classifier_unit.sv
// Each transaction passes through the chain of registered rule cells in order to its result.
// Throughput: one transaction per cycle; the cell chain advances as a whole and
// holds while the result at its end is stalled.
// Rule writes travel the chain in order with packets, so no ordering hazards.
// Reset clears the chain valid bits and rule_count; rule slots stay undefined.
`timescale 1ns / 1ps

module packet_rule_classifier_unit import prc_pkg::*; #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data
);

  logic [CountW-1:0] rule_count_r;
  logic              adv;
  stage_t            entry_st;
  stage_t            st [0:MAX_RULES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rule_count_r <= cfg_data;
    end
  end

  assign adv      = !st[MAX_RULES].valid || !out_stall;
  assign in_stall = !adv;

  // entry slot: writes are already decided, packets start undecided
  always_comb begin
    entry_st.valid   = in_valid;
    entry_st.item    = in_item;
    entry_st.decided = (in_item.op == OP_WRITE);
    if (in_item.op == OP_WRITE) begin
      entry_st.res = '{verdict: VERDICT_ACCEPT, cause: CAUSE_WRITE,
                       rule_hit: HitW'(in_item.rule_index)};
    end else begin
      entry_st.res = '{verdict: VERDICT_ACCEPT, cause: CAUSE_NONE, rule_hit: NO_HIT};
    end
  end

  assign st[0] = entry_st;

  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
    prc_cell #(.CELL_IDX(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .rule_count(rule_count_r),
      .st_in     (st[k]),
      .st_out    (st[k+1])
    );
  end

  assign out_valid = st[MAX_RULES].valid;
  assign out_item  = st[MAX_RULES].res;

  a_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.verdict == VERDICT_DROP) == (out_item.cause == CAUSE_DROP)))
    else $error("verdict and cause disagree");

  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.cause == CAUSE_NONE) |-> (out_item.rule_hit == NO_HIT))
    else $error("undecided packet carries a rule index");

  a_write_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && st[MAX_RULES].item.op == OP_WRITE) |-> (out_item.cause == CAUSE_WRITE))
    else $error("rule write did not report write done");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled chain lost or changed its result");

endmodule

### sim/packet_rule_classifier_unit_tb.sv
// Self-checking testbench for packet_rule_classifier_unit: directed table, then random
// rule writes and packet classifies with stall and idle phases.
// Depends on prc_pkg and packet_rule_classifier_unit.
`timescale 1ns / 1ps

module packet_rule_classifier_unit_tb;
  import prc_pkg::*;

  localparam int unsigned RULES = 64;
  localparam logic [7:0] PROTO_ESP    = 8'd50;  // no address rules, always "unknown"
  localparam logic [7:0] PROTO_OTHER  = 8'd99;
  localparam logic [7:0] ICMP_UNREACH = 8'd3;

  typedef struct {
    bit                set_cnt;
    logic [CountW-1:0] cnt;
    bit                typed;
    in_item_t          item;
    out_item_t         res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data = '0;

  // rule table as the classifier should hold it
  logic [7:0]  tab_proto [RULES];
  logic [31:0] tab_src   [RULES];
  logic [31:0] tab_dst   [RULES];
  logic [15:0] tab_sport [RULES];
  logic [15:0] tab_dport [RULES];
  logic        tab_wl    [RULES];
  int          active_rules = 0;

  out_item_t   verdicts_due[$];
  dir_row_t    dir_rows[$];
  logic [31:0] addr_pool [8];
  logic [15:0] port_pool [6];
  int          snd_pct = 0;
  int          rcv_pct = 0;
  int          mismatches = 0;
  bit          hold_req;
  bit          hold_on;

  packet_rule_classifier_unit #(.MAX_RULES(RULES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t res_of(logic v, logic [2:0] c, logic [HitW-1:0] h);
    out_item_t r;
    r.verdict  = v;
    r.cause    = c;
    r.rule_hit = h;
    return r;
  endfunction

  function automatic in_item_t pkt(logic op, logic [IndexW-1:0] idx, logic [7:0] proto,
                                   logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                   logic [15:0] dp, logic [7:0] itype, logic wl);
    in_item_t it;
    it.op         = op;
    it.rule_index = idx;
    it.protocol   = proto;
    it.src_addr   = sa;
    it.dst_addr   = da;
    it.src_port   = sp;
    it.dst_port   = dp;
    it.icmp_type  = itype;
    it.whitelist  = wl;
    return it;
  endfunction

  function automatic bit addrs_ok(int r, logic [31:0] a, logic [31:0] b);
    return (tab_src[r] == '0 || tab_src[r] == a) && (tab_dst[r] == '0 || tab_dst[r] == b);
  endfunction

  function automatic bit ports_ok(int r, logic [15:0] sp, logic [15:0] dp);
    return (tab_sport[r] == '0 || tab_sport[r] == sp) &&
           (tab_dport[r] == '0 || tab_dport[r] == dp);
  endfunction

  // Expected verdict of one transaction; a rule write also updates the table.
  function automatic out_item_t judge_item(in_item_t it);
    int n;
    bit hit;
    if (it.op == OP_WRITE) begin
      tab_proto[it.rule_index] = it.protocol;
      tab_src[it.rule_index]   = it.src_addr;
      tab_dst[it.rule_index]   = it.dst_addr;
      tab_sport[it.rule_index] = it.src_port;
      tab_dport[it.rule_index] = it.dst_port;
      tab_wl[it.rule_index]    = it.whitelist;
      return res_of(VERDICT_ACCEPT, CAUSE_WRITE, HitW'(it.rule_index));
    end
    n = (active_rules > RULES) ? RULES : active_rules;
    for (int r = 0; r < n; r++) begin
      if (tab_wl[r] && tab_dst[r] == it.dst_addr)
        return res_of(VERDICT_ACCEPT, CAUSE_WHITELIST, HitW'(r));
      if (tab_proto[r] == PROTO_ANY) begin
        hit = addrs_ok(r, it.dst_addr, it.src_addr);
      end else if (tab_proto[r] != it.protocol) begin
        hit = 1'b0;
      end else begin
        case (tab_proto[r])
          PROTO_ICMP: begin
            if (it.icmp_type == ICMP_ECHO_REPLY) hit = addrs_ok(r, it.dst_addr, it.src_addr);
            else if (it.icmp_type == ICMP_ECHO_REQ) hit = addrs_ok(r, it.src_addr, it.dst_addr);
            else hit = 1'b0;
          end
          PROTO_TCP, PROTO_UDP: begin
            hit = addrs_ok(r, it.src_addr, it.dst_addr) && ports_ok(r, it.src_port, it.dst_port);
          end
          PROTO_IGMP, PROTO_EGP, PROTO_IPV6, PROTO_OSPF: begin
            hit = addrs_ok(r, it.dst_addr, it.src_addr);
          end
          default: return res_of(VERDICT_ACCEPT, CAUSE_UNKNOWN, HitW'(r));
        endcase
      end
      if (hit) return res_of(VERDICT_DROP, CAUSE_DROP, HitW'(r));
    end
    return res_of(VERDICT_ACCEPT, CAUSE_NONE, NO_HIT);
  endfunction

  function automatic in_item_t rand_raw();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(9))
      0: return PROTO_ANY;
      1: return PROTO_ICMP;
      2: return PROTO_IGMP;
      3: return PROTO_TCP;
      4: return PROTO_EGP;
      5: return PROTO_UDP;
      6: return PROTO_IPV6;
      7: return PROTO_OSPF;
      8: return PROTO_ESP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Rules draw from small pools so that packets hit them; zero is the wildcard.
  function automatic in_item_t rand_rule(logic [IndexW-1:0] slot);
    in_item_t it;
    it = rand_raw();
    it.op         = OP_WRITE;
    it.rule_index = slot;
    if ($urandom_range(9) != 0) begin
      it.protocol = pick_proto();
      it.src_addr = ($urandom_range(9) < 3) ? '0 : addr_pool[$urandom_range(7)];
      it.dst_addr = ($urandom_range(9) < 3) ? '0 : addr_pool[$urandom_range(7)];
      it.src_port = ($urandom_range(9) < 4) ? '0 : port_pool[$urandom_range(5)];
      it.dst_port = ($urandom_range(9) < 4) ? '0 : port_pool[$urandom_range(5)];
      it.whitelist = ($urandom_range(99) < 15);
    end
    return it;
  endfunction

  function automatic in_item_t rand_pkt();
    in_item_t it;
    it = rand_raw();
    it.op = OP_CLASSIFY;
    if ($urandom_range(9) >= 2) begin
      it.protocol = pick_proto();
      it.src_addr = ($urandom_range(9) == 0) ? '0 : addr_pool[$urandom_range(7)];
      it.dst_addr = ($urandom_range(9) == 0) ? '0 : addr_pool[$urandom_range(7)];
      it.src_port = port_pool[$urandom_range(5)];
      it.dst_port = port_pool[$urandom_range(5)];
      case ($urandom_range(2))
        0: it.icmp_type = ICMP_ECHO_REPLY;
        1: it.icmp_type = ICMP_ECHO_REQ;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic add_row(bit typed, in_item_t it, out_item_t r);
    dir_row_t row;
    row.set_cnt = 1'b0;
    row.cnt     = '0;
    row.typed   = typed;
    row.item    = it;
    row.res     = r;
    dir_rows.push_back(row);
  endtask

  task automatic add_count(logic [CountW-1:0] v);
    dir_row_t row;
    row.set_cnt = 1'b1;
    row.cnt     = v;
    row.typed   = 1'b0;
    row.item    = '0;
    row.res     = '0;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t pred;
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = judge_item(it);
    verdicts_due.push_back(typed ? typed_res : pred);
  endtask

  // Only written with the chain empty: every transaction yields one result.
  task automatic set_rule_count(logic [CountW-1:0] v);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    active_rules = v;
  endtask

  task automatic log_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected verdict %0d cause %0d hit %0d, got %0d %0d %0d", $realtime,
               what, want.verdict, want.cause, want.rule_hit, got.verdict, got.cause,
               got.rule_hit);
  endtask

  always @(posedge clk) begin : rx
    out_item_t want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        log_mismatch("unexpected result", '0, out_item);
      end else begin
        want = verdicts_due.pop_front();
        if (out_item.verdict !== want.verdict || out_item.cause !== want.cause ||
            out_item.rule_hit !== want.rule_hit)
          log_mismatch("result mismatch", want, out_item);
      end
    end
    out_stall <= hold_on || (rcv_pct != 0 && $urandom_range(99) < rcv_pct);
  end

  // long receiver hold-off so the chain fills and backs up the input
  initial begin : hold_off
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("[packet_rule_classifier_unit] ERROR");
    $finish;
  end

  initial begin : stim
    int cnt;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);

    // empty table: everything passes with no hit
    add_row(1, pkt(OP_CLASSIFY, '0, '0, '0, '0, '0, '0, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_NONE, NO_HIT));
    add_row(1, pkt(OP_CLASSIFY, '1, '1, '1, '1, '1, '1, '1, 1'b1),
            res_of(VERDICT_ACCEPT, CAUSE_NONE, NO_HIT));
    add_row(1, pkt(OP_WRITE, 6'd0, PROTO_TCP, '0, 32'h0A00_0001, '0, '0, '0, 1'b1),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd0));
    add_row(1, pkt(OP_WRITE, 6'd1, PROTO_TCP, 32'h0A00_0002, 32'h0A00_0003, 16'd1234,
                   16'd80, '0, 1'b0), res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd1));
    add_row(1, pkt(OP_WRITE, 6'd2, PROTO_UDP, '0, '0, '0, 16'd53, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd2));
    add_row(1, pkt(OP_WRITE, 6'd3, PROTO_ICMP, 32'hC0A8_0001, '0, '0, '0, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd3));
    add_row(1, pkt(OP_WRITE, 6'd4, PROTO_IGMP, '0, 32'h0B00_0001, '0, '0, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd4));
    add_row(1, pkt(OP_WRITE, 6'd5, PROTO_ESP, '0, '0, '0, '0, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd5));
    add_row(1, pkt(OP_WRITE, 6'd6, PROTO_ANY, 32'hDEAD_0001, 32'hBEEF_0001, '0, '0, '0, 1'b0),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd6));
    add_row(1, pkt(OP_WRITE, '1, '1, '1, '1, '1, '1, '1, 1'b1),
            res_of(VERDICT_ACCEPT, CAUSE_WRITE, 7'd63));
    add_count(7'd7);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_TCP, 32'h1, 32'h0A00_0001, 16'd5, 16'd6, '0, 1'b0),
            '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_TCP, 32'h0A00_0002, 32'h0A00_0003, 16'd1234,
                   16'd80, '0, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_TCP, 32'h0A00_0002, 32'h0A00_0003, 16'd1234,
                   16'd81, '0, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_UDP, 32'h5, 32'h6, 16'd999, 16'd53, '0, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_ICMP, 32'hC0A8_0001, 32'h0102_0304, '0, '0,
                   ICMP_ECHO_REQ, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_ICMP, 32'h0102_0304, 32'hC0A8_0001, '0, '0,
                   ICMP_ECHO_REPLY, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_ICMP, 32'hC0A8_0001, 32'hC0A8_0001, '0, '0,
                   ICMP_UNREACH, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_IGMP, 32'h0B00_0001, 32'h7, '0, '0, '0, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_ESP, 32'h8, 32'h9, '0, '0, '0, 1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '0, PROTO_OTHER, 32'hBEEF_0001, 32'hDEAD_0001, '0, '0, '0,
                   1'b0), '0);
    add_row(0, pkt(OP_CLASSIFY, '1, '1, '1, '1, '1, '1, '1, 1'b1), '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cnt) set_rule_count(dir_rows[i].cnt);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    // fill every slot so any rule count reads written rules only
    for (int s = 0; s < RULES; s++) send_item(rand_rule(IndexW'(s)), 1'b0, '0);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: cnt = RULES;
        1: cnt = 0;
        2: cnt = 127;
        3: cnt = 1;
        4: cnt = RULES + 1;
        default: cnt = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(RULES);
      endcase
      set_rule_count(CountW'(cnt));
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 77; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 77; end
        default: begin snd_pct = 29; rcv_pct = 29; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 145; k++) begin
        if ($urandom_range(99) < 15)
          send_item(rand_rule(IndexW'($urandom_range(RULES - 1))), 1'b0, '0);
        else
          send_item(rand_pkt(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (RULES + 16) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("[packet_rule_classifier_unit] OK");
    else
      $display("[packet_rule_classifier_unit] ERROR");
    $finish;
  end

endmodule
